// ===== hdl/iepc_pkg.sv =====
// Shared types and constants for the input edge pulse classifier.
// No dependencies.
`default_nettype none

package iepc_pkg;

   localparam int CHANNELS_DEFAULT       = 32;
   localparam int DURATION_WIDTH_DEFAULT = 24;

   localparam int SAMPLE_W    = 32;
   localparam int ELAPSED_W   = 16;
   localparam int CHANNEL_W   = 5;
   localparam int KIND_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int THRESHOLD_W = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANGE_MODE_MASK     = 2'd0,
      CSR_NOTIFY_ENABLE_MASK   = 2'd1,
      CSR_LONG_THRESHOLD_TICKS = 2'd2
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0]  CHANGE_MODE_RESET = 32'd25;
   localparam logic [CSR_DATA_W-1:0]  NOTIFY_EN_RESET   = 32'd0;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET   = 24'd500;

   typedef enum logic [KIND_W-1:0] {
      EV_ACTIVATED   = 2'd0,
      EV_DEACTIVATED = 2'd1,
      EV_SHORT       = 2'd2,
      EV_LONG        = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic capture;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic event_here;
      logic out_free;
      logic at_end;
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/input_edge_pulse_classifier_top.sv =====
// Top level of the input edge pulse classifier: controller, datapath, registers.
// Depends on iepc_pkg, iepc_csr, iepc_ctrl, iepc_dpath.
`default_nettype none

// Takes one sample word of up to 32 lines plus elapsed ticks and emits one
// result word per edge event, in ascending channel order, last marking the
// final event of the sample. Channels are scanned one per cycle while the
// result port does not stall; the next sample is taken the cycle after the
// scan ends. High time per channel is held in a CHANNELS-entry register file
// read once per scan step and saturates at 2^DURATION_WIDTH - 1. Register
// writes are accepted every cycle and must only be issued while the block is
// idle.
module input_edge_pulse_classifier_top #(
   parameter int CHANNELS       = iepc_pkg::CHANNELS_DEFAULT,
   parameter int DURATION_WIDTH = iepc_pkg::DURATION_WIDTH_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [iepc_pkg::SAMPLE_W-1:0]      req_sample_bits,
   input  wire  [iepc_pkg::ELAPSED_W-1:0]     req_elapsed_ticks,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [iepc_pkg::CHANNEL_W-1:0]     rsp_channel,
   output logic [iepc_pkg::KIND_W-1:0]        rsp_event_kind,
   output logic                               rsp_last,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [iepc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [iepc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import iepc_pkg::*;

   cmd_type                cmd;
   status_type             status;
   logic [CSR_DATA_W-1:0]  change_mode_mask;
   logic [CSR_DATA_W-1:0]  notify_enable_mask;
   logic [THRESHOLD_W-1:0] long_threshold;

   iepc_csr u_csr (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .change_mode_mask   (change_mode_mask),
      .notify_enable_mask (notify_enable_mask),
      .long_threshold     (long_threshold)
   );

   iepc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   iepc_dpath #(
      .CHANNELS       (CHANNELS),
      .DURATION_WIDTH (DURATION_WIDTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_sample_bits    (req_sample_bits),
      .req_elapsed_ticks  (req_elapsed_ticks),
      .change_mode_mask   (change_mode_mask),
      .notify_enable_mask (notify_enable_mask),
      .long_threshold     (long_threshold),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_channel        (rsp_channel),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_last           (rsp_last)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again straight after a word was accepted");

   a_rsp_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.advance) && $past(status.event_here))
      else $error("result word raised without a scan step on an event");

   a_idle_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.advance && status.at_end |=> req_ready)
      else $error("controller not idle after the last channel");

   a_stall_blocks_scan: assert property (@(posedge clock) disable iff (reset)
      status.event_here && !status.out_free |-> !cmd.advance)
      else $error("scan moved on while an event could not be stored");

endmodule

`default_nettype wire

// ===== hdl/iepc_csr.sv =====
// Configuration registers: mode mask, notify mask, long threshold.
// Depends on iepc_pkg.
`default_nettype none

module iepc_csr (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [iepc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [iepc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic [iepc_pkg::CSR_DATA_W-1:0]    change_mode_mask,
   output logic [iepc_pkg::CSR_DATA_W-1:0]    notify_enable_mask,
   output logic [iepc_pkg::THRESHOLD_W-1:0]   long_threshold
);
   import iepc_pkg::*;

   logic [CSR_DATA_W-1:0]  change_mode_ff;
   logic [CSR_DATA_W-1:0]  notify_en_ff;
   logic [THRESHOLD_W-1:0] threshold_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         change_mode_ff <= CHANGE_MODE_RESET;
         notify_en_ff   <= NOTIFY_EN_RESET;
         threshold_ff   <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CHANGE_MODE_MASK:     change_mode_ff <= csr_wdata;
            CSR_NOTIFY_ENABLE_MASK:   notify_en_ff   <= csr_wdata;
            CSR_LONG_THRESHOLD_TICKS: threshold_ff   <= csr_wdata[THRESHOLD_W-1:0];
            default: ;
         endcase
      end
   end

   assign change_mode_mask   = change_mode_ff;
   assign notify_enable_mask = notify_en_ff;
   assign long_threshold     = threshold_ff;

endmodule

`default_nettype wire

// ===== hdl/iepc_ctrl.sv =====
// Scan controller: idle / scan state machine issuing capture and advance.
// Depends on iepc_pkg.
`default_nettype none

module iepc_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  iepc_pkg::status_type   status,
   output iepc_pkg::cmd_type      cmd
);
   import iepc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      advance;

   assign req_ready = (state_ff == ST_IDLE);
   assign advance   = (state_ff == ST_SCAN) && (!status.event_here || status.out_free);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (advance && status.at_end) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.capture = req_valid && req_ready;
   assign cmd.advance = advance;

endmodule

`default_nettype wire

// ===== hdl/iepc_dpath.sv =====
// Datapath: captured edges, per-channel high time, channel counter, result word.
// Depends on iepc_pkg.
`default_nettype none

module iepc_dpath #(
   parameter int CHANNELS       = iepc_pkg::CHANNELS_DEFAULT,
   parameter int DURATION_WIDTH = iepc_pkg::DURATION_WIDTH_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  iepc_pkg::cmd_type                  cmd,
   output iepc_pkg::status_type               status,
   input  wire  [iepc_pkg::SAMPLE_W-1:0]      req_sample_bits,
   input  wire  [iepc_pkg::ELAPSED_W-1:0]     req_elapsed_ticks,
   input  wire  [iepc_pkg::CSR_DATA_W-1:0]    change_mode_mask,
   input  wire  [iepc_pkg::CSR_DATA_W-1:0]    notify_enable_mask,
   input  wire  [iepc_pkg::THRESHOLD_W-1:0]   long_threshold,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [iepc_pkg::CHANNEL_W-1:0]     rsp_channel,
   output logic [iepc_pkg::KIND_W-1:0]        rsp_event_kind,
   output logic                               rsp_last
);
   import iepc_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SUM_W = ((DURATION_WIDTH > ELAPSED_W) ? DURATION_WIDTH : ELAPSED_W) + 1;
   localparam int CMP_W = (DURATION_WIDTH > THRESHOLD_W) ? DURATION_WIDTH : THRESHOLD_W;
   localparam logic [IDX_W-1:0]          LAST_IDX = IDX_W'(CHANNELS - 1);
   localparam logic [DURATION_WIDTH-1:0] DUR_MAX  = {DURATION_WIDTH{1'b1}};

   logic [CHANNELS-1:0]       level_ff;
   logic [CHANNELS-1:0]       rise_ff;
   logic [CHANNELS-1:0]       fall_ff;
   logic [CHANNELS-1:0]       high_ff;
   logic [ELAPSED_W-1:0]      elapsed_ff;
   logic [IDX_W-1:0]          chan_ff;
   logic [DURATION_WIDTH-1:0] duration_ff [CHANNELS];

   logic                      rsp_valid_ff;
   logic [CHANNEL_W-1:0]      rsp_channel_ff;
   event_kind_type            rsp_kind_ff;
   logic                      rsp_last_ff;

   logic [CHANNELS-1:0]       sample_now;
   logic [CHANNELS-1:0]       mode_vec;
   logic [CHANNELS-1:0]       event_vec;
   logic [CHANNELS-1:0]       event_above;
   logic [DURATION_WIDTH-1:0] dur_rd;
   logic [SUM_W-1:0]          dur_sum;
   logic [DURATION_WIDTH-1:0] dur_in;
   event_kind_type            kind_in;
   logic                      out_free;

   assign sample_now = req_sample_bits[CHANNELS-1:0];
   assign mode_vec   = change_mode_mask[CHANNELS-1:0];
   assign event_vec  = ((rise_ff & mode_vec) | fall_ff) & notify_enable_mask[CHANNELS-1:0];
   assign event_above = (event_vec >> chan_ff) >> 1;

   assign dur_rd  = duration_ff[chan_ff];
   assign dur_sum = SUM_W'(dur_rd) + SUM_W'(elapsed_ff);
   assign dur_in  = (dur_sum > SUM_W'(DUR_MAX)) ? DUR_MAX : dur_sum[DURATION_WIDTH-1:0];

   always_comb begin
      priority if (rise_ff[chan_ff]) begin
         kind_in = EV_ACTIVATED;
      end else if (mode_vec[chan_ff]) begin
         kind_in = EV_DEACTIVATED;
      end else if (CMP_W'(dur_rd) < CMP_W'(long_threshold)) begin
         kind_in = EV_SHORT;
      end else begin
         kind_in = EV_LONG;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Edge vectors are taken once per word; the level register moves on at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         chan_ff  <= '0;
      end else if (cmd.capture) begin
         level_ff <= sample_now;
         chan_ff  <= '0;
      end else if (cmd.advance) begin
         chan_ff  <= (chan_ff == LAST_IDX) ? '0 : chan_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rise_ff    <= ~level_ff & sample_now;
         fall_ff    <= level_ff & ~sample_now;
         high_ff    <= level_ff & sample_now;
         elapsed_ff <= req_elapsed_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         if (rise_ff[chan_ff]) begin
            duration_ff[chan_ff] <= '0;
         end else if (high_ff[chan_ff]) begin
            duration_ff[chan_ff] <= dur_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.advance && event_vec[chan_ff]) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.advance && event_vec[chan_ff]) begin
         rsp_channel_ff <= CHANNEL_W'(chan_ff);
         rsp_kind_ff    <= kind_in;
         rsp_last_ff    <= (event_above == '0);
      end
   end

   assign status.event_here = event_vec[chan_ff];
   assign status.out_free   = out_free;
   assign status.at_end     = (chan_ff == LAST_IDX);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_channel    = rsp_channel_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking bench for the input edge pulse classifier: directed edge cases, saturation
// and paced random traffic, each result word checked against an in-bench event predictor.
// Depends on iepc_pkg and input_edge_pulse_classifier_top.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import iepc_pkg::*;

   localparam int NCH         = CHANNELS_DEFAULT;
   localparam int DW          = DURATION_WIDTH_DEFAULT;
   localparam int SCAN_SLACK  = NCH + 16;
   localparam int QUIET_LIMIT = 4000;
   localparam int ITEMS_PER_PHASE = 55;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_SPARE = 2'd3;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      event_kind_type       kind;
      logic                 last;
   } pulse_event_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample_bits = '0;
   logic [ELAPSED_W-1:0]   req_elapsed_ticks = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CHANNEL_W-1:0]   rsp_channel;
   logic [KIND_W-1:0]      rsp_event_kind;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor state
   logic [CSR_DATA_W-1:0]  mode_mask   = CHANGE_MODE_RESET;
   logic [CSR_DATA_W-1:0]  notify_mask = NOTIFY_EN_RESET;
   logic [THRESHOLD_W-1:0] threshold   = THRESHOLD_RESET;
   logic [NCH-1:0]         line_level  = '0;
   logic [DW-1:0]          high_time [NCH] = '{default: '0};

   pulse_event_type pending_events [$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int failures       = 0;
   int samples_taken  = 0;
   int events_checked = 0;
   int csr_writes     = 0;
   int quiet_cycles   = 0;

   input_edge_pulse_classifier_top #(
      .CHANNELS       (NCH),
      .DURATION_WIDTH (DW)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_bits   (req_sample_bits),
      .req_elapsed_ticks (req_elapsed_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel       (rsp_channel),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void classify_sample(input logic [SAMPLE_W-1:0] levels,
                                           input logic [ELAPSED_W-1:0] ticks);
      pulse_event_type found [$];
      pulse_event_type ev;
      logic [DW:0]  sum;
      logic         was_high;
      logic         is_high;
      for (int i = 0; i < NCH; i++) begin
         was_high   = line_level[i];
         is_high    = levels[i];
         ev.channel = CHANNEL_W'(i);
         ev.last    = 1'b0;
         if (!was_high && is_high) begin
            high_time[i] = '0;
            if (mode_mask[i] && notify_mask[i]) begin
               ev.kind = EV_ACTIVATED;
               found.push_back(ev);
            end
         end else if (was_high && !is_high) begin
            if (notify_mask[i]) begin
               if (mode_mask[i])
                  ev.kind = EV_DEACTIVATED;
               else if (high_time[i] < threshold)
                  ev.kind = EV_SHORT;
               else
                  ev.kind = EV_LONG;
               found.push_back(ev);
            end
         end else if (was_high && is_high) begin
            sum = {1'b0, high_time[i]} + ticks;
            high_time[i] = sum[DW] ? '1 : sum[DW-1:0];
         end
         line_level[i] = is_high;
      end
      if (found.size() > 0)
         found[found.size()-1].last = 1'b1;
      foreach (found[k])
         pending_events.push_back(found[k]);
   endfunction

   task automatic flag_mismatch(input string field, input logic [7:0] want, input logic [7:0] got);
      failures++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin : monitor
      pulse_event_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index)
               CSR_CHANGE_MODE_MASK:     mode_mask   = csr_wdata;
               CSR_NOTIFY_ENABLE_MASK:   notify_mask = csr_wdata;
               CSR_LONG_THRESHOLD_TICKS: threshold   = csr_wdata[THRESHOLD_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            samples_taken++;
            classify_sample(req_sample_bits, req_elapsed_ticks);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               failures++;
               $display("%0t: unexpected word, expected none actual ch %0d kind %0d last %0d",
                        $time, rsp_channel, rsp_event_kind, rsp_last);
            end else begin
               want = pending_events.pop_front();
               events_checked++;
               if (want.channel !== rsp_channel)
                  flag_mismatch("channel", 8'(want.channel), 8'(rsp_channel));
               if (want.kind !== rsp_event_kind)
                  flag_mismatch("event_kind", 8'(want.kind), 8'(rsp_event_kind));
               if (want.last !== rsp_last)
                  flag_mismatch("last", 8'(want.last), 8'(rsp_last));
            end
         end
      end
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // leaves csr_valid high; the next send_sample or quiesce drops it
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] levels, input logic [ELAPSED_W-1:0] ticks);
      csr_valid <= 1'b0;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_bits   <= levels;
      req_elapsed_ticks <= ticks;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SCAN_SLACK) @(posedge clock);
   endtask

   task automatic test_reset_values();
      send_sample('1, 16'd100);
      send_sample('0, 16'd0);
      quiesce();
      write_reg(CSR_NOTIFY_ENABLE_MASK, '1);
      send_sample('1, 16'd3);
      send_sample('1, 16'd499);
      send_sample('0, 16'd1);
      send_sample('1, 16'd0);
      send_sample('1, 16'd500);
      send_sample('0, 16'd0);
   endtask

   task automatic test_edge_cases();
      quiesce();
      write_reg(CSR_CHANGE_MODE_MASK, 32'h8000_0001);
      write_reg(CSR_NOTIFY_ENABLE_MASK, 32'hC000_0003);
      write_reg(CSR_LONG_THRESHOLD_TICKS, 32'd1);
      send_sample(32'h0, 16'd0);
      send_sample(32'hFFFF_FFFF, 16'hFFFF);
      send_sample(32'hFFFF_FFFF, 16'd0);
      send_sample(32'h4000_0000, 16'hFFFF);
      send_sample(32'h0, 16'd5);
      send_sample(32'h2, 16'd7);
      send_sample(32'h2, 16'd1);
      send_sample(32'h0, 16'd0);
      quiesce();
      // spare index must leave every register alone
      write_reg(CSR_INDEX_SPARE, 32'hFFFF_FFFF);
      write_reg(CSR_LONG_THRESHOLD_TICKS, 32'd0);
      send_sample(32'h2, 16'd9);
      send_sample(32'h0, 16'd9);
      send_sample(32'h1, 16'd3);
      quiesce();
      // mode is taken at the falling edge
      write_reg(CSR_CHANGE_MODE_MASK, 32'h0);
      send_sample(32'h0, 16'd0);
      quiesce();
      write_reg(CSR_NOTIFY_ENABLE_MASK, 32'h2);
      write_reg(CSR_LONG_THRESHOLD_TICKS, 32'hFF00_0190);
      send_sample(32'h3, 16'd0);
      send_sample(32'h3, 16'd400);
      send_sample(32'h1, 16'd50);
      quiesce();
      // masked channel kept timing
      write_reg(CSR_NOTIFY_ENABLE_MASK, 32'h1);
      send_sample(32'h0, 16'd1);
      send_sample(32'h1, 16'd2);
      send_sample(32'h1, 16'd398);
      send_sample(32'h0, 16'd0);
   endtask

   task automatic test_saturation();
      quiesce();
      write_reg(CSR_CHANGE_MODE_MASK, 32'h0);
      write_reg(CSR_NOTIFY_ENABLE_MASK, 32'h0000_0060);
      write_reg(CSR_LONG_THRESHOLD_TICKS, 32'h00FF_FFFF);
      send_sample(32'h0, 16'd0);
      send_sample(32'h60, 16'd0);
      repeat (256) send_sample(32'h60, 16'hFFFF);
      send_sample(32'h60, 16'd254);
      send_sample(32'h20, 16'd1);
      send_sample(32'h20, 16'hFFFF);
      send_sample(32'h0, 16'd0);
   endtask

   task automatic test_random_traffic();
      int idle_pcts  [4] = '{0, 68, 0, 8};
      int stall_pcts [4] = '{0, 0, 68, 8};
      logic [SAMPLE_W-1:0]   levels;
      logic [ELAPSED_W-1:0]  ticks;
      logic [CSR_DATA_W-1:0] mode;
      logic [CSR_DATA_W-1:0] notify;
      logic [CSR_DATA_W-1:0] thr;
      int pick;
      levels = '0;
      for (int phase = 0; phase < 4; phase++) begin
         quiesce();
         case (phase)
            0: begin
               mode = $urandom; notify = '1; thr = 32'd1;
            end
            1: begin
               mode = '0; notify = $urandom; thr = $urandom_range(1, 3000);
            end
            2: begin
               mode = '1; notify = '1; thr = 32'h00FF_FFFF;
            end
            default: begin
               mode = $urandom; notify = $urandom;
               thr = $urandom_range(1, 3000) | ($urandom & 32'hFF00_0000);
            end
         endcase
         write_reg(CSR_CHANGE_MODE_MASK, mode);
         write_reg(CSR_NOTIFY_ENABLE_MASK, notify);
         write_reg(CSR_LONG_THRESHOLD_TICKS, thr);
         sender_idle_pct    = idle_pcts[phase];
         receiver_stall_pct = stall_pcts[phase];
         repeat (ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 80)
               levels = levels ^ ($urandom & $urandom & $urandom);
            else if (pick < 90)
               levels = $urandom;
            else if (pick < 95)
               levels = '0;
            else
               levels = '1;
            pick = $urandom_range(99);
            if (pick < 75)
               ticks = ELAPSED_W'($urandom_range(0, 300));
            else if (pick < 90)
               ticks = ELAPSED_W'($urandom_range(0, 65535));
            else if (pick < 95)
               ticks = '0;
            else
               ticks = '1;
            send_sample(levels, ticks);
         end
      end
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_edge_cases();
      test_saturation();
      test_random_traffic();
      quiesce();
      if (pending_events.size() != 0) begin
         failures++;
         $display("%0t: %0d events never arrived", $time, pending_events.size());
      end
      $display("ran %0d samples, checked %0d event words, %0d register writes",
               samples_taken, events_checked, csr_writes);
      $display("edges, masking, threshold limits, saturation and four pacing mixes exercised");
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
